@@ rtl/core/pwfd_pkg.sv @@
package pwfd_pkg;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam int INDEX_W = ADDR_W - 2;

  localparam logic [INDEX_W-1:0] REG_FIELD_LIMIT = '0;
  localparam logic [15:0] FIELD_LIMIT_RESET = 16'd128;

  localparam logic [2:0] KIND_VARINT  = 3'd0;
  localparam logic [2:0] KIND_FIXED64 = 3'd1;
  localparam logic [2:0] KIND_LEN     = 3'd2;
  localparam logic [2:0] KIND_FIXED32 = 3'd5;

  typedef enum logic [2:0] {
    PH_TAG    = 3'd0,
    PH_VALUE  = 3'd1,
    PH_FIXED  = 3'd2,
    PH_LENGTH = 3'd3,
    PH_SKIP   = 3'd4
  } phase_t;

  typedef struct packed {
    logic        field_present;
    logic [31:0] field_number;
    logic [2:0]  wire_kind;
    logic [63:0] field_value;
    logic        message_done;
    logic [15:0] field_total;
  } result_t;

endpackage

@@ rtl/core/pwfd_ifs.sv @@
interface pwfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pwfd_out_if;
  logic        valid;
  logic        ready;
  logic        field_present;
  logic [31:0] field_number;
  logic [2:0]  wire_kind;
  logic [63:0] field_value;
  logic        message_done;
  logic [15:0] field_total;

  modport source (
    output valid, output field_present, output field_number, output wire_kind,
    output field_value, output message_done, output field_total, input ready
  );
  modport sink (
    input valid, input field_present, input field_number, input wire_kind,
    input field_value, input message_done, input field_total, output ready
  );
endinterface

@@ rtl/core/pwfd_apb_regs.sv @@
module pwfd_apb_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pwfd_pkg::ADDR_W-1:0] paddr,
  input  logic [pwfd_pkg::DATA_W-1:0] pwdata,
  output logic [pwfd_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output logic [15:0]                 field_limit
);
  import pwfd_pkg::*;

  logic [15:0] field_limit_r;
  logic        sel_limit;
  logic        wr_en;

  assign pready    = 1'b1;
  assign sel_limit = (paddr[ADDR_W-1:2] == REG_FIELD_LIMIT);
  assign wr_en     = psel && penable && pwrite && sel_limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_limit_r <= FIELD_LIMIT_RESET;
    end else if (wr_en) begin
      field_limit_r <= pwdata[15:0];
    end
  end

  assign prdata      = sel_limit ? {{(DATA_W-16){1'b0}}, field_limit_r} : '0;
  assign field_limit = field_limit_r;
endmodule

@@ rtl/core/pwfd_parser.sv @@
module pwfd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic [15:0]       field_limit,
  output logic              res_valid,
  output pwfd_pkg::result_t res
);
  import pwfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        halted_r, halted_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [6:0]  shift_r, shift_nxt;
  logic [31:0] pend_num_r, pend_num_nxt;
  logic [2:0]  pend_kind_r, pend_kind_nxt;
  logic [63:0] remain_r, remain_nxt;
  logic [15:0] count_r, count_nxt;

  logic [7:0]  byte_in;
  logic [63:0] acc_take;
  logic [6:0]  shift_step;
  logic        vr_done;
  logic        vr_long;
  logic        limit_hit;
  logic [63:0] remain_dec;
  logic        remain_zero;
  logic [2:0]  tag_kind;
  logic        got;
  logic [15:0] count_after;

  assign byte_in     = (phase_r == PH_FIXED) ? data_byte : {1'b0, data_byte[6:0]};
  assign acc_take    = acc_r | ({56'd0, byte_in} << shift_r[5:0]);
  assign shift_step  = shift_r + ((phase_r == PH_FIXED) ? 7'd8 : 7'd7);
  assign vr_done     = !data_byte[7];
  assign vr_long     = data_byte[7] && shift_step[6];
  assign limit_hit   = (count_r >= field_limit);
  assign remain_dec  = remain_r - 64'd1;
  assign remain_zero = (remain_dec == 64'd0);
  assign tag_kind    = acc_take[2:0];

  always_comb begin
    phase_nxt  = phase_r;
    halted_nxt = halted_r;
    if (!halted_r) begin
      case (phase_r)
        PH_TAG: begin
          if (limit_hit || vr_long) begin
            halted_nxt = 1'b1;
          end else if (vr_done) begin
            case (tag_kind)
              KIND_VARINT:  phase_nxt = PH_VALUE;
              KIND_FIXED32: phase_nxt = PH_FIXED;
              KIND_FIXED64: phase_nxt = PH_FIXED;
              KIND_LEN:     phase_nxt = PH_LENGTH;
              default:      halted_nxt = 1'b1;
            endcase
          end
        end
        PH_VALUE: begin
          if (vr_long) begin
            halted_nxt = 1'b1;
          end else if (vr_done) begin
            phase_nxt = PH_TAG;
          end
        end
        PH_FIXED: begin
          if (remain_zero) begin
            phase_nxt = PH_TAG;
          end
        end
        PH_LENGTH: begin
          if (vr_long) begin
            halted_nxt = 1'b1;
          end else if (vr_done) begin
            phase_nxt = (acc_take == 64'd0) ? PH_TAG : PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (remain_zero) begin
            phase_nxt = PH_TAG;
          end
        end
        default: phase_nxt = PH_TAG;
      endcase
    end
    if (last_byte) begin
      phase_nxt  = PH_TAG;
      halted_nxt = 1'b0;
    end
  end

  always_comb begin
    acc_nxt       = acc_r;
    shift_nxt     = shift_r;
    pend_num_nxt  = pend_num_r;
    pend_kind_nxt = pend_kind_r;
    remain_nxt    = remain_r;
    got           = 1'b0;
    if (!halted_r) begin
      case (phase_r)
        PH_TAG: begin
          if (!limit_hit) begin
            if (vr_done) begin
              pend_num_nxt  = acc_take[34:3];
              pend_kind_nxt = tag_kind;
              acc_nxt       = '0;
              shift_nxt     = '0;
              if (tag_kind == KIND_FIXED32) begin
                remain_nxt = 64'd4;
              end else if (tag_kind == KIND_FIXED64) begin
                remain_nxt = 64'd8;
              end
            end else begin
              acc_nxt   = acc_take;
              shift_nxt = shift_step;
            end
          end
        end
        PH_VALUE: begin
          if (vr_done) begin
            got       = 1'b1;
            acc_nxt   = '0;
            shift_nxt = '0;
          end else begin
            acc_nxt   = acc_take;
            shift_nxt = shift_step;
          end
        end
        PH_FIXED: begin
          remain_nxt = remain_dec;
          if (remain_zero) begin
            got       = 1'b1;
            acc_nxt   = '0;
            shift_nxt = '0;
          end else begin
            acc_nxt   = acc_take;
            shift_nxt = shift_step;
          end
        end
        PH_LENGTH: begin
          if (vr_done) begin
            remain_nxt = acc_take;
            acc_nxt    = '0;
            shift_nxt  = '0;
          end else begin
            acc_nxt   = acc_take;
            shift_nxt = shift_step;
          end
        end
        PH_SKIP: begin
          remain_nxt = remain_dec;
        end
        default: begin
          acc_nxt   = '0;
          shift_nxt = '0;
        end
      endcase
    end
    count_after = got ? count_r + 16'd1 : count_r;
    count_nxt   = count_after;
    if (last_byte) begin
      acc_nxt       = '0;
      shift_nxt     = '0;
      pend_num_nxt  = '0;
      pend_kind_nxt = '0;
      remain_nxt    = '0;
      count_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TAG;
      halted_r    <= 1'b0;
      acc_r       <= '0;
      shift_r     <= '0;
      pend_num_r  <= '0;
      pend_kind_r <= '0;
      remain_r    <= '0;
      count_r     <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      halted_r    <= halted_nxt;
      acc_r       <= acc_nxt;
      shift_r     <= shift_nxt;
      pend_num_r  <= pend_num_nxt;
      pend_kind_r <= pend_kind_nxt;
      remain_r    <= remain_nxt;
      count_r     <= count_nxt;
    end
  end

  assign res_valid         = accept && (got || last_byte);
  assign res.field_present = got;
  assign res.field_number  = got ? pend_num_r : '0;
  assign res.wire_kind     = got ? pend_kind_r : '0;
  assign res.field_value   = got ? acc_take : '0;
  assign res.message_done  = last_byte;
  assign res.field_total   = last_byte ? count_after : '0;
endmodule

@@ rtl/core/pwfd_out_reg.sv @@
module pwfd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  pwfd_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output pwfd_pkg::result_t out_res,
  output logic              take_ok
);
  import pwfd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign take_ok = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
endmodule

@@ rtl/core/protobuf_wire_field_decoder.sv @@
// Streaming protobuf field decoder: one message word per cycle in, one field record out per
// varint, fixed32 or fixed64 field, plus a result marked done with the field count on the
// last word. Each word's state update and result are formed in a single pass and land in the
// output register, so a new word is taken every cycle while the output side keeps up (ready
// backs off only while a held result is not taken). Length-delimited fields are skipped; a
// bad wire type, an overlong varint or reaching the field limit stops decoding until the end
// of the message. The field limit sits at APB byte address 0.
module protobuf_wire_field_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  pwfd_in_if.sink                     in_ch,
  pwfd_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pwfd_pkg::ADDR_W-1:0] paddr,
  input  logic [pwfd_pkg::DATA_W-1:0] pwdata,
  output logic [pwfd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import pwfd_pkg::*;

  logic        accept;
  logic        take_ok;
  logic [15:0] field_limit;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  assign in_ch.ready = take_ok;
  assign accept      = in_ch.valid && take_ok;

  pwfd_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .field_limit (field_limit)
  );

  pwfd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_ch.data_byte),
    .last_byte   (in_ch.last_byte),
    .field_limit (field_limit),
    .res_valid   (res_valid),
    .res         (res)
  );

  pwfd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_res   (out_res),
    .take_ok   (take_ok)
  );

  assign out_ch.field_present = out_res.field_present;
  assign out_ch.field_number  = out_res.field_number;
  assign out_ch.wire_kind     = out_res.wire_kind;
  assign out_ch.field_value   = out_res.field_value;
  assign out_ch.message_done  = out_res.message_done;
  assign out_ch.field_total   = out_res.field_total;
endmodule

@@ sim/tb_protobuf_wire_field_decoder.sv @@
module tb_protobuf_wire_field_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import pwfd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_WORDS = 220;
  localparam int STALL_CYCLES = 300;
  localparam logic [ADDR_W-1:0] FIELD_LIMIT_ADDR = {REG_FIELD_LIMIT, 2'b00};

  localparam logic [2:0] KIND_START_GROUP = 3'd3;
  localparam logic [2:0] KIND_END_GROUP   = 3'd4;
  localparam logic [2:0] KIND_UNUSED_6    = 3'd6;
  localparam logic [2:0] KIND_UNUSED_7    = 3'd7;

  typedef enum int {VARINT_MORE, VARINT_DONE, VARINT_LONG} varint_status_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pwfd_in_if  in_ch ();
  pwfd_out_if out_ch ();

  protobuf_wire_field_decoder u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // decoder state as seen from outside
  phase_t      dec_phase;
  logic [63:0] dec_acc;
  int unsigned dec_shift;
  logic [31:0] dec_field;
  logic [2:0]  dec_kind;
  logic [63:0] dec_remaining;
  logic [15:0] dec_emitted;
  bit          dec_halted;
  logic [15:0] field_limit_cfg;

  result_t    awaited_results[$];
  logic [7:0] msg_words[$];

  int tx_idle_pct = 25;
  int rx_idle_pct = 87;
  int rx_hold_left = 0;
  int error_count = 0;
  int cycle_count = 0;
  int words_sent = 0;
  int messages_sent = 0;
  int records_seen = 0;
  int dones_seen = 0;
  int settings_used = 0;

  always #2 clk = ~clk;

  function automatic void restart_varint();
    dec_acc = '0;
    dec_shift = 0;
  endfunction

  function automatic void clear_message();
    dec_phase = PH_TAG;
    restart_varint();
    dec_field = '0;
    dec_kind = '0;
    dec_remaining = '0;
    dec_emitted = '0;
    dec_halted = 1'b0;
  endfunction

  function automatic varint_status_t take_varint(logic [7:0] b);
    dec_acc |= 64'(b[6:0]) << (dec_shift & 63);
    if (!b[7]) return VARINT_DONE;
    dec_shift += 7;
    if (dec_shift >= 64) return VARINT_LONG;
    return VARINT_MORE;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input bit is_last,
                                     output result_t res);
    bit             got;
    logic [63:0]    value;
    varint_status_t vstat;
    got = 1'b0;
    value = '0;
    res = '0;
    if (!dec_halted) begin
      case (dec_phase)
        PH_TAG: begin
          if (dec_emitted >= field_limit_cfg) begin
            dec_halted = 1'b1;
          end else begin
            vstat = take_varint(b);
            if (vstat == VARINT_LONG) begin
              dec_halted = 1'b1;
            end else if (vstat == VARINT_DONE) begin
              dec_field = dec_acc[34:3];
              dec_kind = dec_acc[2:0];
              restart_varint();
              case (dec_kind)
                KIND_VARINT: dec_phase = PH_VALUE;
                KIND_FIXED32: begin
                  dec_phase = PH_FIXED;
                  dec_remaining = 64'd4;
                end
                KIND_FIXED64: begin
                  dec_phase = PH_FIXED;
                  dec_remaining = 64'd8;
                end
                KIND_LEN: dec_phase = PH_LENGTH;
                default: dec_halted = 1'b1;
              endcase
            end
          end
        end
        PH_VALUE: begin
          vstat = take_varint(b);
          if (vstat == VARINT_LONG) begin
            dec_halted = 1'b1;
          end else if (vstat == VARINT_DONE) begin
            got = 1'b1;
            value = dec_acc;
            restart_varint();
            dec_phase = PH_TAG;
          end
        end
        PH_FIXED: begin
          dec_acc |= 64'(b) << (dec_shift & 63);
          dec_shift += 8;
          dec_remaining -= 64'd1;
          if (dec_remaining == '0) begin
            got = 1'b1;
            value = dec_acc;
            restart_varint();
            dec_phase = PH_TAG;
          end
        end
        PH_LENGTH: begin
          vstat = take_varint(b);
          if (vstat == VARINT_LONG) begin
            dec_halted = 1'b1;
          end else if (vstat == VARINT_DONE) begin
            dec_remaining = dec_acc;
            restart_varint();
            dec_phase = (dec_remaining == '0) ? PH_TAG : PH_SKIP;
          end
        end
        PH_SKIP: begin
          dec_remaining -= 64'd1;
          if (dec_remaining == '0) dec_phase = PH_TAG;
        end
        default: begin
          dec_phase = PH_TAG;
          restart_varint();
        end
      endcase
      if (got) begin
        dec_emitted += 16'd1;
        res.field_present = 1'b1;
        res.field_number = dec_field;
        res.wire_kind = dec_kind;
        res.field_value = value;
      end
    end
    if (!got && !is_last) return 1'b0;
    res.message_done = is_last;
    res.field_total = is_last ? dec_emitted : '0;
    if (is_last) clear_message();
    return 1'b1;
  endfunction

  function automatic void put_varint(logic [63:0] v, int pad);
    int i;
    while (v >= 64'd128) begin
      msg_words.push_back({1'b1, v[6:0]});
      v = v >> 7;
    end
    msg_words.push_back({1'(pad > 0), v[6:0]});
    for (i = 1; i <= pad; i++) msg_words.push_back({1'(i < pad), 7'd0});
  endfunction

  function automatic void put_tag(logic [31:0] field, logic [2:0] kind, logic [28:0] upper,
                                  int pad);
    put_varint({upper, field, kind}, pad);
  endfunction

  function automatic void put_fixed(logic [63:0] v, int count);
    int i;
    for (i = 0; i < count; i++) msg_words.push_back(v[8*i +: 8]);
  endfunction

  function automatic logic [31:0] pick_field();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
  endfunction

  function automatic int pick_pad();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0;
  endfunction

  function automatic void build_random_message();
    int          fields;
    int          sel;
    int          len;
    int          cut;
    logic [31:0] field;
    logic [28:0] upper;
    logic [2:0]  bad_kind;
    fields = $urandom_range(1, 6);
    repeat (fields) begin
      field = pick_field();
      upper = ($urandom_range(0, 9) == 0) ? 29'($urandom) : '0;
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        put_tag(field, KIND_VARINT, upper, pick_pad());
        put_varint(pick_value(), pick_pad());
      end else if (sel < 55) begin
        put_tag(field, KIND_FIXED32, upper, pick_pad());
        put_fixed(pick_value(), 4);
      end else if (sel < 70) begin
        put_tag(field, KIND_FIXED64, upper, pick_pad());
        put_fixed(pick_value(), 8);
      end else if (sel < 85) begin
        len = $urandom_range(0, 6);
        put_tag(field, KIND_LEN, upper, pick_pad());
        put_varint(64'(len), pick_pad());
        repeat (len) msg_words.push_back(8'($urandom));
      end else if (sel < 90) begin
        case ($urandom_range(0, 3))
          0: bad_kind = KIND_START_GROUP;
          1: bad_kind = KIND_END_GROUP;
          2: bad_kind = KIND_UNUSED_6;
          default: bad_kind = KIND_UNUSED_7;
        endcase
        put_tag(field, bad_kind, upper, 0);
        msg_words.push_back(8'($urandom));
      end else if (sel < 95) begin
        repeat ($urandom_range(1, 4)) msg_words.push_back(8'($urandom));
      end else begin
        put_tag(field, KIND_VARINT, upper, 0);
        repeat (10) msg_words.push_back({1'b1, 7'($urandom)});
      end
    end
    // cut the message short now and then
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, msg_words.size());
      while (msg_words.size() > cut) void'(msg_words.pop_back());
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit is_last);
    result_t res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= is_last;
    do @(posedge clk); while (!in_ch.ready);
    if (decode_byte(b, is_last, res)) awaited_results.push_back(res);
    words_sent++;
    if (is_last) messages_sent++;
  endtask

  task automatic send_message();
    int n;
    int i;
    n = msg_words.size();
    for (i = 0; i < n; i++) send_byte(msg_words[i], i == n - 1);
    msg_words.delete();
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_read_check();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= FIELD_LIMIT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== field_limit_cfg) begin
      error_count++;
      $display("%0t: field_limit readback mismatch: expected %0d, got %0d",
               $time, field_limit_cfg, prdata[15:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_field_limit(input logic [15:0] value);
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FIELD_LIMIT_ADDR;
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    field_limit_cfg = value;
    settings_used++;
    cfg_read_check();
  endtask

  task automatic test_register_reset();
    cfg_read_check();
  endtask

  task automatic test_wire_kinds();
    put_tag(32'd1, KIND_VARINT, '0, 0);
    put_varint(64'd0, 0);
    put_tag(32'd2, KIND_FIXED64, '0, 0);
    put_fixed('1, 8);
    put_tag(32'd3, KIND_LEN, '0, 0);
    put_varint(64'd2, 0);
    msg_words.push_back(8'hAA);
    msg_words.push_back(8'h55);
    put_tag(32'd4, KIND_LEN, '0, 0);
    put_varint(64'd0, 0);
    put_tag(32'd5, KIND_FIXED32, '0, 0);
    put_fixed(64'h0403_0201, 4);
    send_message();
    // widest tag and widest value; tag bits above the field number drop
    put_tag('1, KIND_VARINT, '1, 0);
    put_varint('1, 0);
    send_message();
  endtask

  task automatic test_decode_errors();
    put_tag(32'd1, KIND_START_GROUP, '0, 0);
    put_tag(32'd1, KIND_VARINT, '0, 0);
    send_message();
    put_tag(32'd1, KIND_END_GROUP, '0, 0);
    send_message();
    put_tag(32'd1, KIND_UNUSED_6, '0, 0);
    send_message();
    put_tag(32'd1, KIND_UNUSED_7, '0, 0);
    send_message();
    repeat (10) msg_words.push_back(8'h80);
    put_tag(32'd1, KIND_VARINT, '0, 0);
    send_message();
    put_tag(32'd1, KIND_VARINT, '0, 0);
    msg_words.push_back(8'h80);
    send_message();
    put_tag(32'd1, KIND_FIXED32, '0, 0);
    msg_words.push_back(8'h01);
    send_message();
    put_tag(32'd1, KIND_LEN, '0, 0);
    put_varint(64'd5, 0);
    msg_words.push_back(8'h01);
    send_message();
  endtask

  task automatic test_field_limit();
    logic [15:0] limit_list[2];
    int          i;
    limit_list[0] = 16'd1;
    limit_list[1] = 16'hFFFF;
    for (i = 0; i < 2; i++) begin
      program_field_limit(limit_list[i]);
      put_tag(32'd1, KIND_VARINT, '0, 0);
      put_varint(64'd1, 0);
      put_tag(32'd2, KIND_VARINT, '0, 0);
      put_varint(64'd2, 0);
      send_message();
    end
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                     input logic [15:0] limit);
    int start;
    program_field_limit(limit);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = words_sent;
    while (words_sent - start < PHASE_WORDS) begin
      build_random_message();
      send_message();
    end
  endtask

  task automatic test_output_stall();
    int i;
    program_field_limit(FIELD_LIMIT_RESET);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_left = STALL_CYCLES;
    for (i = 1; i <= 40; i++) begin
      put_tag(32'(i), KIND_VARINT, '0, 0);
      put_varint(64'(i * 3), 0);
    end
    send_message();
    wait_drained();
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] seen);
    if (seen !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, seen);
    end
  endfunction

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: present %0d field %0h kind %0d", $time,
                 out_ch.field_present, out_ch.field_number, out_ch.wire_kind);
        $display("%0t: unexpected result: value %0h done %0d total %0d", $time,
                 out_ch.field_value, out_ch.message_done, out_ch.field_total);
      end else begin
        want = awaited_results.pop_front();
        check_field("field_present", want.field_present, out_ch.field_present);
        check_field("field_number", want.field_number, out_ch.field_number);
        check_field("wire_kind", want.wire_kind, out_ch.wire_kind);
        check_field("field_value", want.field_value, out_ch.field_value);
        check_field("message_done", want.message_done, out_ch.message_done);
        check_field("field_total", want.field_total, out_ch.field_total);
      end
      if (out_ch.field_present) records_seen++;
      if (out_ch.message_done) dones_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
      $display("FAIL protobuf_wire_field_decoder");
      $finish;
    end
  end

  initial begin
    field_limit_cfg = FIELD_LIMIT_RESET;
    clear_message();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_register_reset();
    test_wire_kinds();
    test_decode_errors();
    test_field_limit();
    test_random_traffic(25, 87, 16'($urandom_range(2, 5)));
    test_random_traffic(87, 25, 16'hFFFF);
    test_output_stall();
    test_random_traffic(0, 0, 16'($urandom_range(1, 65535)));
    wait_drained();

    $display("Sent %0d messages in %0d words across %0d field limit settings;",
             messages_sent, words_sent, settings_used);
    $display("checked %0d field records and %0d end-of-message results, %0d mismatches.",
             records_seen, dones_seen, error_count);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("PASS protobuf_wire_field_decoder");
    end else begin
      $display("FAIL protobuf_wire_field_decoder");
    end
    $finish;
  end

endmodule
